// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is asserted.
`define SQC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked at the edge after the antecedent.
`define SQC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sqc_pkg.sv =====
`timescale 1ns / 1ps

package sqc_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CAP_W = 5;
    localparam int OCC_W = 5;
    localparam int VAL_W = 32;
    localparam int MEM_W = VAL_W + 1;
    // Wide enough for both the capacity register and an index plus one.
    localparam int CMP_W = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_PUSHED  = 3'd0,
        ST_ROTATED = 3'd1,
        ST_REMOVED = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [MEM_W-1:0] wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    // Capacity clamped to the range 1 .. DEPTH.
    function automatic logic [CMP_W-1:0] cap_in_effect(input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] c;
        c = CMP_W'(cap);
        if (c == '0) begin
            c = CMP_W'(1);
        end else if (c > CMP_W'(DEPTH)) begin
            c = CMP_W'(DEPTH);
        end
        return c;
    endfunction

    // Step an index by one, wrapping at the capacity in effect.
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CMP_W-1:0] cap_eff);
        logic [CMP_W-1:0] nxt;
        nxt = CMP_W'(idx) + CMP_W'(1);
        if (nxt >= cap_eff) begin
            return '0;
        end
        return nxt[IDX_W-1:0];
    endfunction

endpackage

// ===== src/sqc_ram.sv =====
`timescale 1ns / 1ps

module sqc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 33,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/sqc_ctrl.sv =====
`timescale 1ns / 1ps

module sqc_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sqc_pkg::CAP_W-1:0]       cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic signed [sqc_pkg::VAL_W-1:0] s_value,
    input  logic                            s_chance_flag,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_status,
    output logic signed [sqc_pkg::VAL_W-1:0] m_item_value,
    output logic [sqc_pkg::OCC_W-1:0]       m_occupancy,
    output sqc_pkg::mem_req_t               mem_req,
    input  logic [sqc_pkg::MEM_W-1:0]       mem_rd_data
);

    typedef enum logic {
        IDLE,
        READ
    } state_t;

    state_t                        state_reg, state_next;
    logic [sqc_pkg::IDX_W-1:0]     head_reg, head_next;
    logic [sqc_pkg::IDX_W-1:0]     tail_reg, tail_next;
    logic [sqc_pkg::OCC_W-1:0]     count_reg, count_next;
    logic [sqc_pkg::CAP_W-1:0]     cap_reg;
    logic                          m_valid_reg, m_valid_next;
    sqc_pkg::status_t              status_reg, status_next;
    logic signed [sqc_pkg::VAL_W-1:0] item_reg, item_next;
    logic [sqc_pkg::OCC_W-1:0]     occ_reg, occ_next;

    logic [sqc_pkg::CMP_W-1:0]     cap_eff;
    logic                          in_xfer;
    logic                          out_free;
    logic [sqc_pkg::IDX_W-1:0]     push_idx;
    logic                          rd_flag;
    logic signed [sqc_pkg::VAL_W-1:0] rd_value;

    assign cap_eff  = sqc_pkg::cap_in_effect(cap_reg);
    assign out_free = !m_valid_reg || m_ready;
    // The memory is read only for a step taken while idle, a cycle with no write,
    // and the rotation write lands in the READ state that follows, so a read never meets a write in flight.
    assign s_ready  = (state_reg == IDLE) && out_free;
    assign in_xfer  = s_valid && s_ready;
    assign push_idx = (count_reg == '0) ? '0 : tail_reg;
    assign rd_flag  = mem_rd_data[sqc_pkg::VAL_W];
    assign rd_value = $signed(mem_rd_data[sqc_pkg::VAL_W-1:0]);

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        item_next    = item_reg;
        occ_next     = occ_reg;
        mem_req      = '0;

        case (state_reg)
            IDLE: begin
                if (in_xfer) begin
                    if (sqc_pkg::op_t'(s_opcode) == sqc_pkg::OP_PUSH) begin
                        m_valid_next = 1'b1;
                        item_next    = '0;
                        if (sqc_pkg::CMP_W'(count_reg) >= cap_eff) begin
                            status_next = sqc_pkg::ST_FULL;
                            occ_next    = count_reg;
                        end else begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = push_idx;
                            mem_req.wr_data = {s_chance_flag, s_value};
                            if (count_reg == '0) begin
                                head_next = '0;
                            end
                            tail_next   = sqc_pkg::advance(push_idx, cap_eff);
                            count_next  = count_reg + sqc_pkg::OCC_W'(1);
                            status_next = sqc_pkg::ST_PUSHED;
                            occ_next    = count_reg + sqc_pkg::OCC_W'(1);
                        end
                    end else if (count_reg == '0) begin
                        m_valid_next = 1'b1;
                        item_next    = '0;
                        status_next  = sqc_pkg::ST_EMPTY;
                        occ_next     = count_reg;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = head_reg;
                        state_next      = READ;
                    end
                end
            end
            READ: begin
                head_next    = sqc_pkg::advance(head_reg, cap_eff);
                item_next    = rd_value;
                m_valid_next = 1'b1;
                state_next   = IDLE;
                if (rd_flag) begin
                    // The head gets its second chance: back in at the tail, flag cleared.
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = tail_reg;
                    mem_req.wr_data = {1'b0, rd_value};
                    tail_next       = sqc_pkg::advance(tail_reg, cap_eff);
                    status_next     = sqc_pkg::ST_ROTATED;
                    occ_next        = count_reg;
                end else begin
                    count_next  = count_reg - sqc_pkg::OCC_W'(1);
                    status_next = sqc_pkg::ST_REMOVED;
                    occ_next    = count_reg - sqc_pkg::OCC_W'(1);
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            cap_reg     <= sqc_pkg::CAP_W'(16);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
        status_reg <= status_next;
        item_reg   <= item_next;
        occ_reg    <= occ_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_item_value = item_reg;
    assign m_occupancy  = occ_reg;

endmodule

// ===== src/second_chance_fifo_queue.sv =====
`timescale 1ns / 1ps
// A push or a rejected operation shows its result in the cycle after its transfer; a step
// that reaches the head first reads the head slot and shows its result after the READ state.
// One push or rejection per cycle while the result is not stalled; a step holds s_ready low
// in the READ state while the registered read of the slot memory brings the head entry in.
// Reset: head, tail and count go to zero and capacity to 16; the slot memory is not cleared.

module second_chance_fifo_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [sqc_pkg::CAP_W-1:0]        cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic signed [sqc_pkg::VAL_W-1:0] s_value,
    input  logic                             s_chance_flag,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_status,
    output logic signed [sqc_pkg::VAL_W-1:0] m_item_value,
    output logic [sqc_pkg::OCC_W-1:0]        m_occupancy
);

    sqc_pkg::mem_req_t           mem_req;
    logic [sqc_pkg::MEM_W-1:0]   mem_rd_data;

    sqc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_value       (s_value),
        .s_chance_flag (s_chance_flag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_item_value  (m_item_value),
        .m_occupancy   (m_occupancy),
        .mem_req       (mem_req),
        .mem_rd_data   (mem_rd_data)
    );

    sqc_ram #(
        .DEPTH (sqc_pkg::DEPTH),
        .WIDTH (sqc_pkg::MEM_W),
        .AW    (sqc_pkg::IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== src/sqc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sqc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [2:0]                       m_status,
    input logic signed [sqc_pkg::VAL_W-1:0] m_item_value,
    input logic [sqc_pkg::OCC_W-1:0]        m_occupancy
);

    logic carries_no_item;
    logic leaves_entries;

    assign carries_no_item = (m_status == sqc_pkg::ST_PUSHED) || (m_status == sqc_pkg::ST_FULL)
                             || (m_status == sqc_pkg::ST_EMPTY);
    assign leaves_entries  = (m_status == sqc_pkg::ST_PUSHED) || (m_status == sqc_pkg::ST_ROTATED)
                             || (m_status == sqc_pkg::ST_FULL);

    // A stalled result keeps its contents.
    `SQC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_item_value) && $stable(m_occupancy), "result changed while stalled")

    // Only a rotation or a removal carries a value out.
    `SQC_ASSERT_IMPL(a_item_zero, aclk, aresetn, m_valid && carries_no_item, m_item_value == '0, "nonzero value on a push or rejection")

    // A successful push or rotation, or a full rejection, leaves the queue nonempty.
    `SQC_ASSERT_IMPL(a_occ_nonzero, aclk, aresetn, m_valid && leaves_entries, m_occupancy != '0, "empty queue after push or rotation")

    // An empty rejection reports an empty queue.
    `SQC_ASSERT_IMPL(a_empty_occ, aclk, aresetn, m_valid && m_status == sqc_pkg::ST_EMPTY, m_occupancy == '0, "empty rejection with entries held")

    // Occupancy never exceeds the slot count.
    `SQC_ASSERT_IMPL(a_occ_max, aclk, aresetn, m_valid, 32'(m_occupancy) <= 32'(sqc_pkg::DEPTH), "occupancy beyond depth")

endmodule

bind second_chance_fifo_queue sqc_checker u_sqc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_item_value (m_item_value),
    .m_occupancy  (m_occupancy)
);
